>>> rtl/hgc_pkg.sv
// ============================================================================
// hgc_pkg
// Shared constants, gradient tables and stage payload types of the height
// gradient colorizer.
// ============================================================================
package hgc_pkg;

    // Default height width
    localparam int HEIGHT_BITS_DEF = 16;

    // Fixed-point formats
    localparam int Q_BITS     = 16;                 // Q0.16 normalized height and factor
    localparam int D_BITS     = 15;                 // offset into a segment, below 26214
    localparam int RECIP_BITS = 23;                 // reciprocal of a segment width
    localparam int QW_BITS    = Q_BITS + D_BITS;    // quotient times segment width
    localparam int PROD_BITS  = D_BITS + RECIP_BITS;
    localparam int CH_BITS    = 8;
    localparam int CH_COUNT   = 3;
    localparam int COLOR_BITS = CH_BITS * CH_COUNT;
    localparam int MIX_BITS   = CH_BITS + Q_BITS + 2; // signed blend product

    // Gradient stops
    localparam int STOP_COUNT = 6;
    localparam int SEG_COUNT  = STOP_COUNT - 1;
    localparam int SEG_BITS   = 3;

    localparam logic [Q_BITS:0] STOP_POS [STOP_COUNT] = '{
        17'd0, 17'd655, 17'd6554, 17'd26214, 17'd39322, 17'd65536
    };

    localparam logic [COLOR_BITS-1:0] STOP_RGB [STOP_COUNT] = '{
        24'h0000FF, 24'h008800, 24'hFFFF88, 24'h880000, 24'hFFFFFF, 24'hFFFFFF
    };

    // Segment widths, stop k+1 minus stop k
    localparam logic [D_BITS-1:0] SEG_WIDTH [SEG_COUNT] = '{
        15'd655, 15'd5899, 15'd19660, 15'd13108, 15'd26214
    };

    // floor(2^32 / width): estimate of d * 2^16 / width, low by at most one
    localparam logic [RECIP_BITS-1:0] SEG_RECIP [SEG_COUNT] = '{
        23'((64'd1 << 32) / 64'd655),
        23'((64'd1 << 32) / 64'd5899),
        23'((64'd1 << 32) / 64'd19660),
        23'((64'd1 << 32) / 64'd13108),
        23'((64'd1 << 32) / 64'd26214)
    };

    // Configuration register indexes
    localparam logic CFG_HEIGHT_MIN = 1'b0;
    localparam logic CFG_HEIGHT_MAX = 1'b1;

    // Divider result toward the segment stages
    typedef struct packed {
        logic [Q_BITS-1:0] quot;
        logic              sat_lo;
        logic              sat_hi;
        logic              empty;
        logic              last;
    } norm_t;

    // Segment and blend factor toward the blend stages
    typedef struct packed {
        logic [SEG_BITS-1:0] seg;
        logic [Q_BITS-1:0]   f;
        logic                empty;
        logic                last;
    } seg_t;

endpackage

>>> rtl/hgc_divider.sv
// ============================================================================
// hgc_divider
// Front stage that normalizes against the height span, then a pipelined
// restoring divider giving (height - min) * 2^16 / span, two bits a stage.
// ============================================================================
module hgc_divider #(
    parameter int HEIGHT_BITS = hgc_pkg::HEIGHT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [HEIGHT_BITS-1:0] height,
    input  logic                          in_last,
    input  logic signed [HEIGHT_BITS-1:0] height_min,
    input  logic signed [HEIGHT_BITS-1:0] height_max,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hgc_pkg::norm_t                out_data
);
    import hgc_pkg::*;

    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = Q_BITS / BITS_PER_STAGE;
    localparam int N_STAGES       = DIV_STAGES + 1;

    typedef struct packed {
        logic [HEIGHT_BITS-1:0] rem;
        logic [HEIGHT_BITS-1:0] span;
        logic [Q_BITS-1:0]      quot;
        logic                   sat_lo;
        logic                   sat_hi;
        logic                   empty;
        logic                   last;
    } div_stage_t;

    // Restoring division steps; remainder stays below span
    function automatic div_stage_t div_step(input div_stage_t s);
        div_stage_t           r;
        logic [HEIGHT_BITS:0] r2;
        r = s;
        for (int i = 0; i < BITS_PER_STAGE; i++) begin
            r2 = {r.rem, 1'b0};
            if (r2 >= {1'b0, r.span}) begin
                r2     = r2 - {1'b0, r.span};
                r.quot = {r.quot[Q_BITS-2:0], 1'b1};
            end
            else begin
                r.quot = {r.quot[Q_BITS-2:0], 1'b0};
            end
            r.rem = r2[HEIGHT_BITS-1:0];
        end
        return r;
    endfunction

    logic [N_STAGES-1:0] vld_reg;
    logic [N_STAGES-1:0] vld_next;
    logic [N_STAGES-1:0] en;
    div_stage_t          pl_reg  [N_STAGES];
    div_stage_t          pl_next [N_STAGES];
    div_stage_t          pl_in   [N_STAGES];
    div_stage_t          prep;
    logic signed [HEIGHT_BITS:0] num_w;
    logic signed [HEIGHT_BITS:0] span_w;

    // Front stage: empty and saturation flags, offset and span
    always_comb
    begin
        num_w       = {height[HEIGHT_BITS-1], height}
                    - {height_min[HEIGHT_BITS-1], height_min};
        span_w      = {height_max[HEIGHT_BITS-1], height_max}
                    - {height_min[HEIGHT_BITS-1], height_min};
        prep.empty  = (height_max <= height_min);
        prep.sat_lo = (height <= height_min);
        prep.sat_hi = (height >= height_max);
        prep.rem    = (!prep.sat_lo && !prep.sat_hi) ? num_w[HEIGHT_BITS-1:0] : '0;
        prep.span   = span_w[HEIGHT_BITS-1:0];
        prep.quot   = '0;
        prep.last   = in_last;
    end

    // Stage inputs
    always_comb
    begin
        pl_in[0] = prep;
        for (int i = 1; i < N_STAGES; i++) begin
            pl_in[i] = div_step(pl_reg[i-1]);
        end
    end

    // A stage loads when empty or when the next one moves on
    always_comb
    begin
        en[N_STAGES-1] = ~vld_reg[N_STAGES-1] | out_ready;
        for (int i = N_STAGES - 2; i >= 0; i--) begin
            en[i] = ~vld_reg[i] | en[i+1];
        end
    end

    always_comb
    begin
        vld_next[0] = en[0] ? in_valid : vld_reg[0];
        pl_next[0]  = en[0] ? pl_in[0] : pl_reg[0];
        for (int i = 1; i < N_STAGES; i++) begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
            pl_next[i]  = en[i] ? pl_in[i] : pl_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pl_reg <= pl_next;
    end

    // Outputs
    assign in_ready        = en[0];
    assign out_valid       = vld_reg[N_STAGES-1];
    assign out_data.quot   = pl_reg[N_STAGES-1].quot;
    assign out_data.sat_lo = pl_reg[N_STAGES-1].sat_lo;
    assign out_data.sat_hi = pl_reg[N_STAGES-1].sat_hi;
    assign out_data.empty  = pl_reg[N_STAGES-1].empty;
    assign out_data.last   = pl_reg[N_STAGES-1].last;

endmodule

>>> rtl/hgc_segment.sv
// ============================================================================
// hgc_segment
// Picks the gradient segment of t and computes the Q0.16 blend factor by
// reciprocal multiply and a one-step correction, over four stages.
// ============================================================================
module hgc_segment (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  hgc_pkg::norm_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output hgc_pkg::seg_t  out_data
);
    import hgc_pkg::*;

    localparam int N_STAGES = 4;

    typedef struct packed {
        logic [SEG_BITS-1:0] seg;
        logic [D_BITS-1:0]   d;
        logic [Q_BITS-1:0]   quot;
        logic [QW_BITS-1:0]  qw;
        logic                empty;
        logic                last;
    } seg_stage_t;

    logic [N_STAGES-1:0] vld_reg;
    logic [N_STAGES-1:0] vld_next;
    logic [N_STAGES-1:0] en;
    seg_stage_t          pl_reg  [N_STAGES];
    seg_stage_t          pl_next [N_STAGES];
    seg_stage_t          pl_in   [N_STAGES];
    logic [Q_BITS-1:0]   t;
    logic [Q_BITS-1:0]   t_off;
    logic [PROD_BITS-1:0] prod;
    logic [QW_BITS-1:0]  rem;

    // Stage 0: resolve saturation, select segment, offset into it
    always_comb
    begin
        priority if (in_data.sat_hi) begin
            t = '1;
        end
        else if (in_data.sat_lo) begin
            t = '0;
        end
        else begin
            t = in_data.quot;
        end
        pl_in[0]      = '0;
        pl_in[0].seg  = '0;
        for (int j = 1; j < SEG_COUNT; j++) begin
            if ({1'b0, t} >= STOP_POS[j]) begin
                pl_in[0].seg = pl_in[0].seg + SEG_BITS'(1);
            end
        end
        t_off          = t - STOP_POS[pl_in[0].seg][Q_BITS-1:0];
        pl_in[0].d     = t_off[D_BITS-1:0];
        pl_in[0].empty = in_data.empty;
        pl_in[0].last  = in_data.last;
    end

    // Stage 1: quotient estimate from the reciprocal
    always_comb
    begin
        pl_in[1]      = pl_reg[0];
        prod          = {{RECIP_BITS{1'b0}}, pl_reg[0].d}
                      * {{D_BITS{1'b0}}, SEG_RECIP[pl_reg[0].seg]};
        pl_in[1].quot = prod[2*Q_BITS-1:Q_BITS];
    end

    // Stage 2: estimate times segment width
    always_comb
    begin
        pl_in[2]    = pl_reg[1];
        pl_in[2].qw = {{D_BITS{1'b0}}, pl_reg[1].quot}
                    * {{Q_BITS{1'b0}}, SEG_WIDTH[pl_reg[1].seg]};
    end

    // Stage 3: correct an estimate that came out one low
    always_comb
    begin
        pl_in[3] = pl_reg[2];
        rem      = {pl_reg[2].d, {Q_BITS{1'b0}}} - pl_reg[2].qw;
        if (rem >= {{Q_BITS{1'b0}}, SEG_WIDTH[pl_reg[2].seg]}) begin
            pl_in[3].quot = pl_reg[2].quot + Q_BITS'(1);
        end
    end

    // Stall chain
    always_comb
    begin
        en[N_STAGES-1] = ~vld_reg[N_STAGES-1] | out_ready;
        for (int i = N_STAGES - 2; i >= 0; i--) begin
            en[i] = ~vld_reg[i] | en[i+1];
        end
    end

    always_comb
    begin
        vld_next[0] = en[0] ? in_valid : vld_reg[0];
        pl_next[0]  = en[0] ? pl_in[0] : pl_reg[0];
        for (int i = 1; i < N_STAGES; i++) begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
            pl_next[i]  = en[i] ? pl_in[i] : pl_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pl_reg <= pl_next;
    end

    // Outputs
    assign in_ready       = en[0];
    assign out_valid      = vld_reg[N_STAGES-1];
    assign out_data.seg   = pl_reg[N_STAGES-1].seg;
    assign out_data.f     = pl_reg[N_STAGES-1].quot;
    assign out_data.empty = pl_reg[N_STAGES-1].empty;
    assign out_data.last  = pl_reg[N_STAGES-1].last;

endmodule

>>> rtl/hgc_blend.sv
// ============================================================================
// hgc_blend
// Per-channel linear blend between the two stop colors of a segment,
// rounded half up; the second stage is the block's output register.
// ============================================================================
module hgc_blend (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  hgc_pkg::seg_t                    in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [hgc_pkg::COLOR_BITS-1:0]   color,
    output logic                             last
);
    import hgc_pkg::*;

    logic                                 mul_vld_reg;
    logic                                 mul_vld_next;
    logic [CH_COUNT-1:0][CH_BITS-1:0]     base_reg;
    logic [CH_COUNT-1:0][CH_BITS-1:0]     base_next;
    logic [CH_COUNT-1:0][MIX_BITS-1:0]    mix_reg;
    logic [CH_COUNT-1:0][MIX_BITS-1:0]    mix_next;
    logic                                 mul_last_reg;
    logic                                 mul_last_next;
    logic                                 out_vld_reg;
    logic                                 out_vld_next;
    logic [COLOR_BITS-1:0]                color_reg;
    logic [COLOR_BITS-1:0]                color_next;
    logic                                 last_reg;
    logic                                 last_next;
    logic                                 en_mul;
    logic                                 en_out;
    logic [COLOR_BITS-1:0]                rgb_a;
    logic [COLOR_BITS-1:0]                rgb_b;
    logic [Q_BITS-1:0]                    f;
    logic signed [CH_BITS:0]              diff;
    logic signed [MIX_BITS-1:0]           sum;

    assign en_out   = ~out_vld_reg | out_ready;
    assign en_mul   = ~mul_vld_reg | en_out;
    assign in_ready = en_mul;

    // Stage 0: stop colors and (b - a) * f per channel
    always_comb
    begin
        if (in_data.empty) begin
            rgb_a = STOP_RGB[0];
            rgb_b = STOP_RGB[0];
            f     = '0;
        end
        else begin
            rgb_a = STOP_RGB[in_data.seg];
            rgb_b = STOP_RGB[in_data.seg + SEG_BITS'(1)];
            f     = in_data.f;
        end
        base_next     = base_reg;
        mix_next      = mix_reg;
        mul_last_next = mul_last_reg;
        mul_vld_next  = mul_vld_reg;
        diff          = '0;
        if (en_mul) begin
            mul_vld_next  = in_valid;
            mul_last_next = in_data.last;
            for (int c = 0; c < CH_COUNT; c++) begin
                diff = $signed({1'b0, rgb_b[c*CH_BITS +: CH_BITS]})
                     - $signed({1'b0, rgb_a[c*CH_BITS +: CH_BITS]});
                base_next[c] = rgb_a[c*CH_BITS +: CH_BITS];
                mix_next[c]  = MIX_BITS'(diff * $signed({1'b0, f}));
            end
        end
    end

    // Stage 1: a * 2^16 + mix + half, keep the integer byte
    always_comb
    begin
        color_next   = color_reg;
        last_next    = last_reg;
        out_vld_next = out_vld_reg;
        sum          = '0;
        if (en_out) begin
            out_vld_next = mul_vld_reg;
            last_next    = mul_last_reg;
            for (int c = 0; c < CH_COUNT; c++) begin
                sum = $signed({2'b00, base_reg[c], {Q_BITS{1'b0}}})
                    + $signed(mix_reg[c])
                    + $signed(MIX_BITS'(1) << (Q_BITS - 1));
                color_next[c*CH_BITS +: CH_BITS] = sum[Q_BITS +: CH_BITS];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mul_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else begin
            mul_vld_reg <= mul_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        mix_reg      <= mix_next;
        mul_last_reg <= mul_last_next;
        color_reg    <= color_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_vld_reg;
    assign color     = color_reg;
    assign last      = last_reg;

endmodule

>>> rtl/height_gradient_colorizer_unit.sv
// ============================================================================
// height_gradient_colorizer_unit
// Maps a stream of signed vertex heights to 24-bit gradient colors.
// ============================================================================
// Takes one height transaction per clock while s_axis_tready is high and
// returns one color transaction for each, in order, through one normalizing
// stage, eight divider stages (two quotient bits each), four segment and
// factor stages and two blend stages, the last being the output register.
// s_axis_tready drops only when every stage holds data and m_axis_tready
// is low. height_min and height_max are to be written through the cfg port
// only while no transactions are in flight (not enforced). With height_max
// <= height_min every vertex gets the first stop color 0x0000FF.
module height_gradient_colorizer_unit #(
    parameter int HEIGHT_BITS = hgc_pkg::HEIGHT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic                               cfg_index,
    input  logic [HEIGHT_BITS-1:0]             cfg_data,
    // height stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [((HEIGHT_BITS+7)/8)*8-1:0]   s_axis_tdata,  // height
    input  logic                               s_axis_tlast,  // is_last
    // color stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [hgc_pkg::COLOR_BITS-1:0]     m_axis_tdata,  // color 0xRRGGBB
    output logic                               m_axis_tlast   // is_last_res
);
    import hgc_pkg::*;

    logic signed [HEIGHT_BITS-1:0] height_min_reg;
    logic signed [HEIGHT_BITS-1:0] height_min_next;
    logic signed [HEIGHT_BITS-1:0] height_max_reg;
    logic signed [HEIGHT_BITS-1:0] height_max_next;

    norm_t norm_data;
    logic  norm_valid;
    logic  norm_ready;
    seg_t  seg_data;
    logic  seg_valid;
    logic  seg_ready;

    // Configuration registers
    always_comb
    begin
        height_min_next = height_min_reg;
        height_max_next = height_max_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_HEIGHT_MIN: height_min_next = $signed(cfg_data);
                CFG_HEIGHT_MAX: height_max_next = $signed(cfg_data);
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            height_min_reg <= '0;
            height_max_reg <= '0;
        end
        else begin
            height_min_reg <= height_min_next;
            height_max_reg <= height_max_next;
        end
    end

    // Normalize and divide
    hgc_divider #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .height     ($signed(s_axis_tdata[HEIGHT_BITS-1:0])),
        .in_last    (s_axis_tlast),
        .height_min (height_min_reg),
        .height_max (height_max_reg),
        .out_valid  (norm_valid),
        .out_ready  (norm_ready),
        .out_data   (norm_data)
    );

    // Segment and blend factor
    hgc_segment u_segment (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (norm_valid),
        .in_ready  (norm_ready),
        .in_data   (norm_data),
        .out_valid (seg_valid),
        .out_ready (seg_ready),
        .out_data  (seg_data)
    );

    // Color blend and output register
    hgc_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (seg_valid),
        .in_ready  (seg_ready),
        .in_data   (seg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .color     (m_axis_tdata),
        .last      (m_axis_tlast)
    );

endmodule

>>> sim/height_gradient_colorizer_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// height_gradient_colorizer_checker
// Watches the config port and both streams of the colorizer.
// ============================================================================
// It keeps its own copy of height_min and height_max, taken from the cfg
// writes. For every height transaction it computes the gradient color and
// queues it. Each color transaction is compared against the oldest queued
// color, including the last-vertex mark. It reports the failure count and
// the number of colors still outstanding to the testbench top.
module height_gradient_colorizer_checker #(
    parameter int HEIGHT_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_index,
    input  logic [HEIGHT_BITS-1:0]           cfg_data,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [((HEIGHT_BITS+7)/8)*8-1:0] s_axis_tdata,   // height
    input  logic                             s_axis_tlast,   // is_last
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [23:0]                      m_axis_tdata,   // color 0xRRGGBB
    input  logic                             m_axis_tlast,   // is_last_res
    output int                               fail_count,
    output int                               pending_count
);

    typedef struct {
        logic [23:0] color;
        logic        last;
    } color_result_t;

    color_result_t               expected_colors [$];
    logic signed [HEIGHT_BITS-1:0] range_min = '0;
    logic signed [HEIGHT_BITS-1:0] range_max = '0;
    int                          mismatches = 0;

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    // Gradient stop thresholds in Q0.16
    function automatic longint stop_threshold(input int k);
        case (k)
            0:       return 0;
            1:       return 655;
            2:       return 6554;
            3:       return 26214;
            4:       return 39322;
            default: return 65536;
        endcase
    endfunction

    // Gradient stop colors
    function automatic logic [23:0] stop_color(input int k);
        case (k)
            0:       return 24'h0000FF;
            1:       return 24'h008800;
            2:       return 24'hFFFF88;
            3:       return 24'h880000;
            default: return 24'hFFFFFF;
        endcase
    endfunction

    // Normalize the height, pick the segment and blend its two stop colors
    function automatic logic [23:0] gradient_color(
        input logic signed [HEIGHT_BITS-1:0] h,
        input logic signed [HEIGHT_BITS-1:0] lo,
        input logic signed [HEIGHT_BITS-1:0] hi
    );
        longint      t;
        longint      q;
        longint      d;
        longint      w;
        longint      f;
        longint      ca;
        longint      cb;
        longint      ch;
        int          k;
        logic [23:0] rgb_a;
        logic [23:0] rgb_b;
        logic [23:0] rgb;
        // empty or inverted span: first stop color
        if (hi <= lo)
            return 24'h0000FF;
        if (h <= lo)
            t = 0;
        else if (h >= hi)
            t = 65535;
        else
        begin
            q = ((longint'(h) - longint'(lo)) <<< 16) / (longint'(hi) - longint'(lo));
            t = (q > 65535) ? 65535 : q;
        end
        k = 0;
        while (k < 4 && stop_threshold(k + 1) <= t)
            k++;
        d = t - stop_threshold(k);
        w = stop_threshold(k + 1) - stop_threshold(k);
        q = (d <<< 16) / w;
        f = (q > 65535) ? 65535 : q;
        rgb_a = stop_color(k);
        rgb_b = stop_color(k + 1);
        rgb   = '0;
        // per channel, round half up
        for (int sh = 0; sh < 24; sh += 8)
        begin
            ca = rgb_a[sh +: 8];
            cb = rgb_b[sh +: 8];
            ch = (ca * (65536 - f) + cb * f + 32768) >>> 16;
            rgb[sh +: 8] = ch[7:0];
        end
        return rgb;
    endfunction

    // Track config, predict on input transactions, compare on output ones
    always @(posedge clk)
    begin
        color_result_t want;
        if (rst_n)
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == hgc_pkg::CFG_HEIGHT_MIN)
                    range_min = cfg_data;
                else if (cfg_index == hgc_pkg::CFG_HEIGHT_MAX)
                    range_max = cfg_data;
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_colors.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected color transaction %h last %b",
                                 $time, m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    want = expected_colors.pop_front();
                    if (m_axis_tdata !== want.color || m_axis_tlast !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: color mismatch: expected %h last %b, got %h last %b",
                                     $time, want.color, want.last, m_axis_tdata, m_axis_tlast);
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                want.color = gradient_color(s_axis_tdata[HEIGHT_BITS-1:0], range_min, range_max);
                want.last  = s_axis_tlast;
                expected_colors.push_back(want);
            end
        end
        pending_count <= expected_colors.size();
        fail_count    <= mismatches;
    end

endmodule

>>> sim/height_gradient_colorizer_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// height_gradient_colorizer_unit_tb
// Stimulus and verdict for the height gradient colorizer.
// ============================================================================
// Runs a directed set of heights (empty span after reset, full range,
// saturation on both ends, stop boundaries), then several random phases,
// each with its own height range and its own amount of source gaps and
// sink stalls. The range is rewritten only once all colors are back.
// The checker module does the prediction and comparison.
module height_gradient_colorizer_unit_tb;

    localparam int HEIGHT_BITS = 16;
    localparam int TDATA_BITS  = ((HEIGHT_BITS + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 90;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic                   cfg_index;
    logic [HEIGHT_BITS-1:0] cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [TDATA_BITS-1:0]  s_axis_tdata;   // height
    logic                   s_axis_tlast;   // is_last
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [23:0]            m_axis_tdata;   // color 0xRRGGBB
    logic                   m_axis_tlast;   // is_last_res

    int fail_count;
    int pending_count;
    int cycle_count    = 0;
    int src_gap_pct    = 0;
    int sink_stall_pct = 0;
    int sink_hold      = 0;

    always #1 clk = ~clk;

    height_gradient_colorizer_unit #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    height_gradient_colorizer_checker #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Sink: random stall bursts of random length
    always @(posedge clk)
    begin
        if (sink_hold > 0)
        begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if (sink_stall_pct > 0 && $urandom_range(0, 99) < sink_stall_pct)
        begin
            sink_hold     <= $urandom_range(1, 19) - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // One height transaction, optionally preceded by a source gap burst
    task automatic push_height(input int height, input logic last);
        if (src_gap_pct > 0 && $urandom_range(0, 99) < src_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_BITS'(height);
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Hold the source until every queued color has come back
    task automatic wait_colors_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0);
    endtask

    // Write both range registers, block must be idle
    task automatic set_height_range(input int lo, input int hi);
        cfg_wr_en <= 1'b1;
        cfg_index <= hgc_pkg::CFG_HEIGHT_MIN;
        cfg_data  <= HEIGHT_BITS'(lo);
        @(posedge clk);
        cfg_index <= hgc_pkg::CFG_HEIGHT_MAX;
        cfg_data  <= HEIGHT_BITS'(hi);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        int phase_lo [PHASES];
        int phase_hi [PHASES];
        int src_pct_tab [PHASES];
        int sink_pct_tab [PHASES];
        int stops [4];
        int lo;
        int hi;
        int pick;
        int h;
        int a;
        int b;

        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = hgc_pkg::CFG_HEIGHT_MIN;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty span straight out of reset
        push_height(-32768, 1'b0);
        push_height(32767, 1'b1);
        push_height(0, 1'b0);
        wait_colors_drained();

        // Full range: extremes and both sides of every stop
        set_height_range(-32768, 32767);
        push_height(-32768, 1'b1);
        push_height(32767, 1'b0);
        push_height(-1, 1'b0);
        push_height(0, 1'b1);
        stops = '{655, 6554, 26214, 39322};
        foreach (stops[i])
        begin
            push_height(-32768 + stops[i] - 1, 1'b0);
            push_height(-32768 + stops[i], 1'b1);
            push_height(-32768 + stops[i] + 1, 1'b0);
        end
        wait_colors_drained();

        // Saturation below minimum and above maximum
        set_height_range(-1000, 1000);
        push_height(-1001, 1'b0);
        push_height(-1000, 1'b1);
        push_height(1000, 1'b0);
        push_height(1001, 1'b1);
        wait_colors_drained();

        // Random phases
        phase_lo     = '{-32768, -1000, 0, 300, 2000, 32000, 0, 0, 0};
        phase_hi     = '{32767, 1000, 1, 300, -2000, 32767, 0, 0, 0};
        src_pct_tab  = '{0, 20, 5, 30, 10, 0, 25, 5, 0};
        sink_pct_tab = '{10, 0, 25, 5, 30, 15, 0, 20, 0};
        for (int p = 6; p < PHASES; p++)
        begin
            a = int'($urandom_range(0, 65535)) - 32768;
            b = int'($urandom_range(0, 65535)) - 32768;
            // the seventh phase may come out inverted, the eighth and ninth are ordered
            if (p != 6 && a > b)
            begin
                phase_lo[p] = b;
                phase_hi[p] = a;
            end
            else
            begin
                phase_lo[p] = a;
                phase_hi[p] = b;
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            lo = phase_lo[p];
            hi = phase_hi[p];
            set_height_range(lo, hi);
            src_gap_pct    = src_pct_tab[p];
            sink_stall_pct <= sink_pct_tab[p];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7 && hi > lo)
                    h = lo + int'($urandom_range(0, hi - lo));
                else if (pick == 7)
                    h = $urandom_range(0, 1) ? lo : hi;
                else
                    h = int'($urandom_range(0, 65535)) - 32768;
                push_height(h, $urandom_range(0, 15) == 0);
                // in the second phase the source holds off mid-phase until the pipe is empty
                if (p == 1 && n == PHASE_ITEMS / 2)
                    wait_colors_drained();
            end
            wait_colors_drained();
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> height_gradient_colorizer_unit.f
rtl/hgc_pkg.sv
rtl/hgc_divider.sv
rtl/hgc_segment.sv
rtl/hgc_blend.sv
rtl/height_gradient_colorizer_unit.sv
sim/height_gradient_colorizer_checker.sv
sim/height_gradient_colorizer_unit_tb.sv
